@@ rtl/dtc_pkg.sv @@
// ----------------------------------------------------------------------------
// dtc_pkg - shared definitions for the dual timer/counter register block
// Item kinds, word register indexes, reset values and the per-timer
// control bundle.
// ----------------------------------------------------------------------------
package dtc_pkg;

    // Width of one timer count and limit
    localparam int COUNT_BITS_DEFAULT = 28;

    // Item kinds carried on the input channel
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Word register indexes
    localparam logic [2:0] REG_LIMIT0    = 3'd0;
    localparam logic [2:0] REG_LIMIT1    = 3'd1;
    localparam logic [2:0] REG_COUNT0    = 3'd2;
    localparam logic [2:0] REG_COUNT1    = 3'd3;
    localparam logic [2:0] REG_CONTROL   = 3'd4;
    localparam logic [2:0] REG_INTERRUPT = 3'd5;
    localparam logic [2:0] REG_DIVIDER   = 3'd6;

    // Configuration port register index (from paddr[2])
    localparam logic CFG_CLOCK_DIVIDER = 1'b0;

    localparam logic [15:0] DIVIDER_RESET = 16'd1;

    // Per-timer command for one processed item
    typedef struct packed {
        logic step;          // divided step happens on this item
        logic enabled;       // timer enable bit
        logic counter_mode;  // wrap at limit instead of holding
        logic restart;       // enable rising edge: load zero
        logic limit_we;      // load the limit register
    } timer_ctl_t;

endpackage

@@ rtl/dual_timer_counter_regs.sv @@
// ----------------------------------------------------------------------------
// dual_timer_counter_regs - two-timer peripheral with word register access
// Items are register reads, register writes or base clock ticks; each item
// gives one result with the read value and the interrupt line.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register, then one pass of register
//   decode and timer update writes its result into the result register.
// Throughput: one item per cycle while results are taken; the input register
//   and the result register each advance whenever the next stage frees, so a
//   stalled result costs no more than the items already held.
// Reset: synchronous on aresetn low; all timer state clears, the divider loads 1.
// ----------------------------------------------------------------------------
module dual_timer_counter_regs #(
    parameter int COUNT_BITS = dtc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] reg_index, [34:3] write_data, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] read_data, [32] interrupt_line, rest zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Bit position of the value field inside limit and count words
    localparam int SHIFT = 32 - COUNT_BITS;

    // ---------------- input register ----------------
    logic        in_valid_reg;
    logic [1:0]  in_mode_reg;
    logic [2:0]  in_idx_reg;
    logic [31:0] in_wdata_reg;

    // ---------------- result register ----------------
    logic        out_valid_reg;
    logic [31:0] out_rdata_reg, rdata_next;
    logic        out_irq_reg, irq_next;

    // ---------------- block state ----------------
    logic [3:0]  control_reg, control_next;
    logic [1:0]  irq_en_reg, irq_en_next;
    logic [1:0]  pend_reg, pend_next, pend_cmd;
    logic [15:0] prescale_reg, prescale_next;
    logic [15:0] div_reg, div_next;
    logic [15:0] div_eff;

    logic        advance;
    logic        process;
    logic        cfg_write;

    dtc_pkg::timer_ctl_t   ctl0, ctl1;
    logic [COUNT_BITS-1:0] count0, count1, limit0, limit1, limit_wdata;
    logic [31:0]           wdata_shifted;
    logic                  fire0, fire1;

    // Free the result register when it is empty or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == dtc_pkg::CFG_CLOCK_DIVIDER) ? {16'b0, div_reg} : 32'b0;

    // Limit value sits in the upper bits of the written word
    assign wdata_shifted = in_wdata_reg >> SHIFT;
    assign limit_wdata   = wdata_shifted[COUNT_BITS-1:0];
    assign div_eff       = (div_reg == 16'd0) ? 16'd1 : div_reg;

    dtc_timer #(.COUNT_BITS(COUNT_BITS)) u_timer0 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl0),
        .limit_wdata (limit_wdata),
        .count       (count0),
        .limit       (limit0),
        .fire        (fire0)
    );

    dtc_timer #(.COUNT_BITS(COUNT_BITS)) u_timer1 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl1),
        .limit_wdata (limit_wdata),
        .count       (count1),
        .limit       (limit1),
        .fire        (fire1)
    );

    // Decode the held item and form the next state
    always_comb begin
        control_next  = control_reg;
        irq_en_next   = irq_en_reg;
        pend_cmd      = pend_reg;
        prescale_next = prescale_reg;
        div_next      = div_reg;
        rdata_next    = 32'b0;
        ctl0          = '0;
        ctl1          = '0;
        // Control bits: [3] timer0 enable, [2] timer0 counter mode,
        // [1] timer1 enable, [0] timer1 counter mode
        ctl0.enabled      = control_reg[3];
        ctl0.counter_mode = control_reg[2];
        ctl1.enabled      = control_reg[1];
        ctl1.counter_mode = control_reg[0];

        // Users must keep the stream side idle for configuration writes; unenforced
        if (cfg_write && paddr[2] == dtc_pkg::CFG_CLOCK_DIVIDER) begin
            div_next = pwdata[15:0];
        end

        if (process) begin
            case (in_mode_reg)
                dtc_pkg::MODE_READ: begin
                    case (in_idx_reg)
                        dtc_pkg::REG_LIMIT0:    rdata_next = 32'(limit0) << SHIFT;
                        dtc_pkg::REG_LIMIT1:    rdata_next = 32'(limit1) << SHIFT;
                        dtc_pkg::REG_COUNT0:    rdata_next = 32'(count0) << SHIFT;
                        dtc_pkg::REG_COUNT1:    rdata_next = 32'(count1) << SHIFT;
                        dtc_pkg::REG_CONTROL:   rdata_next = {control_reg, 28'b0};
                        dtc_pkg::REG_INTERRUPT: rdata_next = {irq_en_reg, pend_reg, 28'b0};
                        dtc_pkg::REG_DIVIDER:   rdata_next = {div_reg, 16'b0};
                        default:                rdata_next = 32'b0;
                    endcase
                end
                dtc_pkg::MODE_WRITE: begin
                    case (in_idx_reg)
                        dtc_pkg::REG_LIMIT0: ctl0.limit_we = 1'b1;
                        dtc_pkg::REG_LIMIT1: ctl1.limit_we = 1'b1;
                        dtc_pkg::REG_CONTROL: begin
                            // Restart a timer on the rising edge of its enable
                            ctl0.restart = !control_reg[3] && in_wdata_reg[31];
                            ctl1.restart = !control_reg[1] && in_wdata_reg[29];
                            control_next = in_wdata_reg[31:28];
                        end
                        dtc_pkg::REG_INTERRUPT: begin
                            irq_en_next = in_wdata_reg[31:30];
                            // Write one to clear a pending flag
                            pend_cmd    = pend_reg & ~in_wdata_reg[29:28];
                        end
                        dtc_pkg::REG_DIVIDER: div_next = in_wdata_reg[31:16];
                        default: ;
                    endcase
                end
                dtc_pkg::MODE_TICK: begin
                    if (({1'b0, prescale_reg} + 17'd1) >= {1'b0, div_eff}) begin
                        prescale_next = 16'd0;
                        ctl0.step     = 1'b1;
                        ctl1.step     = 1'b1;
                    end else begin
                        prescale_next = prescale_reg + 16'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Pending bits: [1] timer0, [0] timer1
    assign pend_next = pend_cmd | {fire0, fire1};
    assign irq_next  = |(pend_next & irq_en_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            control_reg   <= 4'b0;
            irq_en_reg    <= 2'b0;
            pend_reg      <= 2'b0;
            prescale_reg  <= 16'd0;
            div_reg       <= dtc_pkg::DIVIDER_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            control_reg  <= control_next;
            irq_en_reg   <= irq_en_next;
            pend_reg     <= pend_next;
            prescale_reg <= prescale_next;
            div_reg      <= div_next;
        end
    end

    // Payload registers: capture on accept, update on process
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg  <= s_tuser;
            in_idx_reg   <= s_tdata[2:0];
            in_wdata_reg <= s_tdata[34:3];
        end
        if (process) begin
            out_rdata_reg <= rdata_next;
            out_irq_reg   <= irq_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_irq_reg, out_rdata_reg};

    // ---------------- assertions ----------------

    // A held result carries the interrupt of the current state
    a_irq_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_irq_reg == |(pend_reg & irq_en_reg)))
        else $error("result interrupt does not match pending and enable state");

    // A disabled timer0 holds its count through a tick
    a_disabled_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && in_mode_reg == dtc_pkg::MODE_TICK && !control_reg[3])
        |=> $stable(count0))
        else $error("disabled timer0 changed its count");

    // A stalled input item is neither lost nor overwritten
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_idx_reg)
                                        && $stable(in_mode_reg)))
        else $error("stalled input item was dropped or overwritten");

    // Pending only rises on a tick
    a_pend_rise_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        ((pend_next & ~pend_reg) != 2'b0) |-> (process && in_mode_reg == dtc_pkg::MODE_TICK))
        else $error("pending flag set outside a tick");

endmodule

@@ rtl/dtc_timer.sv @@
// ----------------------------------------------------------------------------
// dtc_timer - one timer channel
// Holds the limit and count of one timer and applies one divided step,
// a restart or a limit load per processed item.
// ----------------------------------------------------------------------------
module dtc_timer #(
    parameter int COUNT_BITS = dtc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dtc_pkg::timer_ctl_t    ctl,
    input  logic [COUNT_BITS-1:0]  limit_wdata,
    output logic [COUNT_BITS-1:0]  count,
    output logic [COUNT_BITS-1:0]  limit,
    output logic                   fire
);

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] limit_reg, limit_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  held;

    always_comb begin
        count_inc  = count_reg + 1'b1;
        held       = !ctl.counter_mode && (count_reg == limit_reg);
        limit_next = ctl.limit_we ? limit_wdata : limit_reg;
        count_next = count_reg;
        fire       = 1'b0;
        if (ctl.restart) begin
            count_next = '0;
        end else if (ctl.step && ctl.enabled && !held) begin
            if (count_inc == limit_reg) begin
                fire       = 1'b1;
                count_next = ctl.counter_mode ? '0 : count_inc;
            end else begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            limit_reg <= '0;
        end else begin
            count_reg <= count_next;
            limit_reg <= limit_next;
        end
    end

    assign count = count_reg;
    assign limit = limit_reg;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for the dual timer/counter register block
// A short table of directed items covers register extremes, the read-only
// counts, the unused index and mode, timer and counter behavior and divider
// corner cases. Random items then run through several divider settings.
// Every result is compared against an in-bench timer model or a typed row,
// while both stream sides idle at random outside one calm phase.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = dtc_pkg::COUNT_BITS_DEFAULT;   // count width
    localparam int SH = 32 - CB;                       // value position in a word
    localparam logic [2:0] REG_UNUSED  = 3'd7;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int IDLE_PCT     = 22;    // idle cycles per hundred, each side
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
    localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up
    localparam int PHASE_ITEMS  = 190;   // random items per divider setting
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result returns
    localparam int MAX_REPORTS  = 10;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [2:0] reg_index, [34:3] write_data, rest zero
    logic [1:0]  s_tuser;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] read_data, [32] interrupt_line, rest zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dual_timer_counter_regs #(
        .COUNT_BITS(CB)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Expected results and directed table
    // ------------------------------------------------------------------------
    typedef struct {
        logic [31:0] rd;
        logic        irq;
    } tmr_result_t;

    typedef struct {
        logic [1:0]  mode;
        logic [2:0]  idx;
        logic [31:0] wd;
        logic        typed;   // rd/irq below are the expected result
        logic [31:0] rd;
        logic        irq;
    } tmr_row_t;

    tmr_result_t result_q[$];
    tmr_row_t    dir_rows[$];

    // Typed expectation travels beside the item so the monitor sees it on accept
    logic        row_typed;
    logic [31:0] row_rd;
    logic        row_irq;

    int   err_count;
    logic calm;       // no idling on either side
    logic hold_req;   // ask the receiver for one long hold-off

    // ------------------------------------------------------------------------
    // Timer model state
    // ------------------------------------------------------------------------
    logic [CB-1:0] p_lim0, p_lim1, p_cnt0, p_cnt1;
    logic [3:0]    p_ctrl;    // t0 enable, t0 counter mode, t1 enable, t1 counter mode
    logic [1:0]    p_irq_en;  // [1] timer0, [0] timer1
    logic [1:0]    p_pend;    // [1] timer0, [0] timer1
    logic [15:0]   p_presc;
    logic [15:0]   p_div;

    // One divided step of one timer; hit flags the step that reaches the limit
    task automatic advance_timer(inout logic [CB-1:0] cnt, input logic [CB-1:0] lim,
                                 input logic en, input logic cm, output logic hit);
        logic [CB-1:0] nxt;
        hit = 1'b0;
        // a one-shot timer parked on its limit stays put
        if (en && (cm || cnt != lim)) begin
            nxt = cnt + 1'b1;
            if (nxt == lim) begin
                cnt = cm ? '0 : nxt;
                hit = 1'b1;
            end else begin
                cnt = nxt;
            end
        end
    endtask

    // Apply one item to the model and return the result it gives
    task automatic apply_item(input logic [1:0] mode, input logic [2:0] idx,
                              input logic [31:0] wd, output logic [31:0] rd,
                              output logic irq);
        logic [15:0] div_eff;
        logic [3:0]  nc;
        logic        hit0, hit1;
        rd = '0;
        case (mode)
            dtc_pkg::MODE_READ: begin
                case (idx)
                    dtc_pkg::REG_LIMIT0:    rd = {p_lim0, {SH{1'b0}}};
                    dtc_pkg::REG_LIMIT1:    rd = {p_lim1, {SH{1'b0}}};
                    dtc_pkg::REG_COUNT0:    rd = {p_cnt0, {SH{1'b0}}};
                    dtc_pkg::REG_COUNT1:    rd = {p_cnt1, {SH{1'b0}}};
                    dtc_pkg::REG_CONTROL:   rd = {p_ctrl, 28'd0};
                    dtc_pkg::REG_INTERRUPT: rd = {p_irq_en, p_pend, 28'd0};
                    dtc_pkg::REG_DIVIDER:   rd = {p_div, 16'd0};
                    default:                rd = '0;
                endcase
            end
            dtc_pkg::MODE_WRITE: begin
                case (idx)
                    dtc_pkg::REG_LIMIT0: p_lim0 = wd[31:SH];
                    dtc_pkg::REG_LIMIT1: p_lim1 = wd[31:SH];
                    dtc_pkg::REG_CONTROL: begin
                        nc = wd[31:28];
                        // a rising enable restarts that timer from zero
                        if (!p_ctrl[3] && nc[3]) p_cnt0 = '0;
                        if (!p_ctrl[1] && nc[1]) p_cnt1 = '0;
                        p_ctrl = nc;
                    end
                    dtc_pkg::REG_INTERRUPT: begin
                        p_irq_en = wd[31:30];
                        p_pend   = p_pend & ~wd[29:28];
                    end
                    dtc_pkg::REG_DIVIDER: p_div = wd[31:16];
                    default: ;   // counts are read only, index 7 is unused
                endcase
            end
            dtc_pkg::MODE_TICK: begin
                div_eff = (p_div == 16'd0) ? 16'd1 : p_div;
                // a divider lowered below the prescaler steps on the next tick
                if ({1'b0, p_presc} + 17'd1 >= {1'b0, div_eff}) begin
                    p_presc = '0;
                    advance_timer(p_cnt0, p_lim0, p_ctrl[3], p_ctrl[2], hit0);
                    advance_timer(p_cnt1, p_lim1, p_ctrl[1], p_ctrl[0], hit1);
                    if (hit0) p_pend[1] = 1'b1;
                    if (hit1) p_pend[0] = 1'b1;
                end else begin
                    p_presc = p_presc + 16'd1;
                end
            end
            default: ;   // unused mode
        endcase
        irq = |(p_pend & p_irq_en);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] exp_rd,
                                   input logic exp_irq, input logic [31:0] got_rd,
                                   input logic got_irq);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t %s: expected read_data %08h irq %0b, got read_data %08h irq %0b",
                     $realtime, what, exp_rd, exp_irq, got_rd, got_irq);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: predict on input accept, check on result accept
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        tmr_result_t want;
        tmr_result_t got;
        if (aresetn) begin
            // pop before push so a stray result cannot match this edge's item
            if (m_tvalid && m_tready) begin
                got.rd  = m_tdata[31:0];
                got.irq = m_tdata[32];
                if (result_q.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, 1'b0,
                                    got.rd, got.irq);
                end else begin
                    want = result_q.pop_front();
                    if (got.rd !== want.rd || got.irq !== want.irq)
                        report_mismatch("result mismatch", want.rd, want.irq,
                                        got.rd, got.irq);
                end
            end
            if (s_tvalid && s_tready) begin
                apply_item(s_tuser, s_tdata[2:0], s_tdata[34:3], want.rd, want.irq);
                // a typed row overrides the model's answer
                if (row_typed) begin
                    want.rd  = row_rd;
                    want.irq = row_irq;
                end
                result_q.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                // hold off long enough for the block to fill and stall its input
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no handshake happens for too long
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_row(input logic [1:0] mode, input logic [2:0] idx,
                           input logic [31:0] wd, input logic typed,
                           input logic [31:0] rd, input logic irq);
        tmr_row_t r;
        r.mode  = mode;
        r.idx   = idx;
        r.wd    = wd;
        r.typed = typed;
        r.rd    = rd;
        r.irq   = irq;
        dir_rows.push_back(r);
    endtask

    // Offer one item after a random gap; return at the edge that accepts it
    task automatic send_item(input logic [1:0] mode, input logic [2:0] idx,
                             input logic [31:0] wd, input logic typed,
                             input logic [31:0] t_rd, input logic t_irq);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= mode;
        s_tdata   <= {5'd0, wd, idx};
        row_typed <= typed;
        row_rd    <= t_rd;
        row_irq   <= t_irq;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write the divider over the configuration port, then read it back
    task automatic cfg_divider(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {dtc_pkg::CFG_CLOCK_DIVIDER, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        p_div = value;
        // keep psel up and go straight into the read-back setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {16'd0, p_div})
            report_mismatch("divider read-back", {16'd0, p_div}, 1'b0, prdata, 1'b0);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [15:0] settings [5];
        logic [1:0]  md;
        logic [2:0]  ix;
        logic [31:0] wd;
        int          sel;

        // drive every input to a known value from time zero
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        row_typed = 1'b0;
        row_rd    = '0;
        row_irq   = 1'b0;
        err_count = 0;
        calm      = 1'b0;
        hold_req  = 1'b0;

        // model state after reset
        p_lim0   = '0;
        p_lim1   = '0;
        p_cnt0   = '0;
        p_cnt1   = '0;
        p_ctrl   = '0;
        p_irq_en = '0;
        p_pend   = '0;
        p_presc  = '0;
        p_div    = dtc_pkg::DIVIDER_RESET;

        // extremes first, then the in-between settings
        settings = '{16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd2};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values, unused index and mode, limit extremes, read-only counts
        add_row(dtc_pkg::MODE_READ,  dtc_pkg::REG_LIMIT0,  32'h0,         1'b1, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_READ,  dtc_pkg::REG_DIVIDER, 32'h0,         1'b1,
                32'h0001_0000, 1'b0);
        add_row(dtc_pkg::MODE_READ,  REG_UNUSED,           32'hFFFF_FFFF, 1'b1, 32'h0,
                1'b0);
        add_row(MODE_UNUSED,         dtc_pkg::REG_LIMIT0,  32'hFFFF_FFFF, 1'b1, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_WRITE, dtc_pkg::REG_LIMIT0,  32'hFFFF_FFFF, 1'b1, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_READ,  dtc_pkg::REG_LIMIT0,  32'h0,         1'b1,
                32'hFFFF_FFF0, 1'b0);
        add_row(dtc_pkg::MODE_WRITE, dtc_pkg::REG_COUNT0,  32'hFFFF_FFFF, 1'b1, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_READ,  dtc_pkg::REG_COUNT0,  32'h0,         1'b1, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_WRITE, REG_UNUSED,           32'hFFFF_FFFF, 1'b1, 32'h0,
                1'b0);
        // timer0 one-shot to 3, timer1 one-shot with a zero limit (never pends)
        add_row(dtc_pkg::MODE_WRITE, dtc_pkg::REG_LIMIT0,    32'h0000_003F, 1'b0, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_WRITE, dtc_pkg::REG_LIMIT1,    32'h0000_000F, 1'b0, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_WRITE, dtc_pkg::REG_INTERRUPT, 32'hC000_0000, 1'b0, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_WRITE, dtc_pkg::REG_CONTROL,   32'hA000_0000, 1'b0, 32'h0,
                1'b0);
        for (int t = 0; t < 4; t++)
            add_row(dtc_pkg::MODE_TICK, dtc_pkg::REG_LIMIT0, 32'h0, 1'b0, 32'h0, 1'b0);
        add_row(dtc_pkg::MODE_READ,  dtc_pkg::REG_COUNT0,    32'h0, 1'b0, 32'h0, 1'b0);
        add_row(dtc_pkg::MODE_READ,  dtc_pkg::REG_INTERRUPT, 32'h0, 1'b0, 32'h0, 1'b0);
        // clear pending, disable and hold, then re-enable in counter mode
        add_row(dtc_pkg::MODE_WRITE, dtc_pkg::REG_INTERRUPT, 32'hF000_0000, 1'b0, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_WRITE, dtc_pkg::REG_CONTROL,   32'h0000_0000, 1'b0, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_TICK,  dtc_pkg::REG_COUNT0,    32'h0,         1'b0, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_WRITE, dtc_pkg::REG_CONTROL,   32'hF000_0000, 1'b0, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_READ,  dtc_pkg::REG_COUNT0,    32'h0,         1'b1, 32'h0,
                1'b0);
        // largest divider, one tick, then drop it below the prescaler
        add_row(dtc_pkg::MODE_WRITE, dtc_pkg::REG_DIVIDER,   32'hFFFF_0000, 1'b1, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_TICK,  dtc_pkg::REG_LIMIT0,    32'h0,         1'b0, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_WRITE, dtc_pkg::REG_DIVIDER,   32'h0000_FFFF, 1'b1, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_TICK,  dtc_pkg::REG_LIMIT0,    32'h0,         1'b0, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_READ,  dtc_pkg::REG_DIVIDER,   32'h0,         1'b1, 32'h0,
                1'b0);
        add_row(dtc_pkg::MODE_READ,  dtc_pkg::REG_COUNT1,    32'h0,         1'b0, 32'h0,
                1'b0);

        foreach (dir_rows[i])
            send_item(dir_rows[i].mode, dir_rows[i].idx, dir_rows[i].wd,
                      dir_rows[i].typed, dir_rows[i].rd, dir_rows[i].irq);

        for (int ph = 0; ph < 5; ph++) begin
            // the divider is only rewritten over the configuration port with the block empty
            drain();
            cfg_divider(settings[ph]);
            calm = (ph == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == 40)
                    hold_req = 1'b1;
                if (ph == 0 && k == 100)
                    drain();

                sel = $urandom_range(0, 99);
                ix  = 3'($urandom_range(0, 7));
                wd  = $urandom;
                if (sel < 45) begin
                    md = dtc_pkg::MODE_TICK;
                end else if (sel < 70) begin
                    md = dtc_pkg::MODE_READ;
                end else if (sel < 96) begin
                    md = dtc_pkg::MODE_WRITE;
                    // keep limits and dividers small so timers actually fire
                    if ((ix == dtc_pkg::REG_LIMIT0 || ix == dtc_pkg::REG_LIMIT1)
                        && $urandom_range(0, 7) != 0)
                        wd = {CB'($urandom_range(0, 40)), wd[SH-1:0]};
                    else if (ix == dtc_pkg::REG_DIVIDER && $urandom_range(0, 9) != 0)
                        wd = {16'($urandom_range(0, 4)), wd[15:0]};
                    else if (ix == dtc_pkg::REG_INTERRUPT && $urandom_range(0, 1) != 0)
                        wd[29:28] = 2'b00;
                end else begin
                    md = MODE_UNUSED;
                end
                send_item(md, ix, wd, 1'b0, 32'h0, 1'b0);
            end
        end
        calm = 1'b0;
        drain();

        if (err_count == 0 && result_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
